FILE: rtl/mphp_pkg.sv
`timescale 1ns / 1ps

package mphp_pkg;

  localparam logic [7:0]  SIG_B0        = 8'h4D;  // 'M'
  localparam logic [7:0]  SIG_B1        = 8'h50;  // 'P'
  localparam logic [7:0]  SIG_B2        = 8'h2B;  // '+'
  localparam logic [3:0]  SV7_MIN_VER   = 4'd7;
  localparam logic [9:0]  OLD_LONG_VER  = 10'd5;
  localparam int unsigned FRAME_SAMPLES = 1152;
  localparam logic [10:0] DEFAULT_TRIM  = 11'd576;
  localparam logic [15:0] OLD_RATE      = 16'd44100;
  localparam int unsigned KBPS_DIV      = 1000;
  localparam logic [1:0]  CH_STEREO     = 2'd2;

  localparam logic [15:0] RATE_TABLE [4] = '{16'd44100, 16'd48000, 16'd37800, 16'd32000};

  localparam int VER_W  = 10;
  localparam int RATE_W = 16;
  localparam int HBR_W  = 9;
  localparam int SECS_W = 18;
  localparam int BR_W   = 26;

  // duration divider: (samples + rate/2) / rate
  localparam int D1_DW = 33;
  localparam int D1_VW = RATE_W;
  // bitrate divider: (length * 8) / (secs * 1000)
  localparam int D2_DW = 35;
  localparam int D2_VW = 28;

  typedef struct packed {
    logic              ok;
    logic [VER_W-1:0]  version;
    logic [31:0]       frames;
    logic [31:0]       samples;
    logic [HBR_W-1:0]  hbr;
    logic [31:0]       len;
  } p1_t;

  typedef struct packed {
    logic              ok;
    logic [VER_W-1:0]  version;
    logic [RATE_W-1:0] rate;
    logic [31:0]       frames;
    logic [31:0]       samples;
    logic [SECS_W-1:0] secs;
    logic [HBR_W-1:0]  hbr;
  } p2_t;

  typedef struct packed {
    logic [D1_DW-1:0] dividend;
    logic [D1_VW-1:0] rate;
    p1_t              pay;
  } dec_t;

endpackage

FILE: rtl/mphp_decode.sv
`timescale 1ns / 1ps

module mphp_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [63:0]         header_low,
  input  logic [31:0]         header_high,
  input  logic [31:0]         stream_length,
  output logic                out_valid,
  output mphp_pkg::dec_t      out_dec
);

  logic                valid_r;
  mphp_pkg::dec_t      dec_r;
  mphp_pkg::dec_t      dec_nxt;

  logic                sig_ok;
  logic [3:0]          nib;
  logic [31:0]         gap;
  logic [31:0]         word0;
  logic [9:0]          old_ver;
  logic [31:0]         frames;
  logic [10:0]         trim;
  logic [15:0]         rate;
  logic [31:0]         samples;

  always_comb begin
    sig_ok  = (header_low[7:0] == mphp_pkg::SIG_B0) && (header_low[15:8] == mphp_pkg::SIG_B1)
              && (header_low[23:16] == mphp_pkg::SIG_B2);
    nib     = header_low[27:24];
    gap     = {header_high[7:0], header_low[63:40]};
    word0   = header_low[31:0];
    old_ver = word0[20:11];
    dec_nxt = '0;
    frames  = header_low[63:32];
    trim    = mphp_pkg::DEFAULT_TRIM;
    rate    = mphp_pkg::OLD_RATE;
    if (nib >= mphp_pkg::SV7_MIN_VER) begin
      rate = mphp_pkg::RATE_TABLE[header_high[17:16]];
      if (gap[31]) begin
        trim = gap[30:20];
      end
    end else if (old_ver < mphp_pkg::OLD_LONG_VER) begin
      frames = {16'd0, header_low[63:48]};
    end
    samples = 32'(frames * 32'(mphp_pkg::FRAME_SAMPLES)) - {21'd0, trim};
    if (sig_ok) begin
      dec_nxt.pay.ok      = 1'b1;
      dec_nxt.pay.version = (nib >= mphp_pkg::SV7_MIN_VER) ? {6'd0, nib} : old_ver;
      dec_nxt.pay.hbr     = (nib >= mphp_pkg::SV7_MIN_VER) ? '0 : word0[31:23];
      dec_nxt.pay.frames  = frames;
      dec_nxt.pay.samples = samples;
      dec_nxt.pay.len     = stream_length;
      dec_nxt.rate        = rate;
      dec_nxt.dividend    = {1'b0, samples} + {18'd0, rate[15:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_dec   = dec_r;

endmodule

FILE: rtl/mphp_div_cell.sv
`timescale 1ns / 1ps

module mphp_div_cell #(
  parameter int DW = mphp_pkg::D1_DW,
  parameter int VW = mphp_pkg::D1_VW,
  parameter int PW = $bits(mphp_pkg::p1_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_rem,
  input  logic [DW-1:0] in_quo,
  input  logic [VW-1:0] in_dvs,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [VW-1:0] out_rem,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_dvs,
  output logic [PW-1:0] out_pay
);

  logic          valid_r;
  logic [VW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] dvs_r;
  logic [PW-1:0] pay_r;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;
  logic [DW-1:0] quo_nxt;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {in_rem, in_quo[DW-1]};
    ge      = trial >= {1'b0, in_dvs};
    diff    = trial - {1'b0, in_dvs};
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    quo_nxt = {in_quo[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= in_dvs;
      pay_r <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_dvs   = dvs_r;
  assign out_pay   = pay_r;

endmodule

FILE: rtl/musepack_header_properties.sv
`timescale 1ns / 1ps

// Channel  Ports          Payload                                   Bits
// input    in_t*          header_low, header_high, stream_length    128
// result   out_t*         header_ok .. bitrate_kbps                 144
//
// One header transfer per cycle unless a held result stalls the chain; the path is decode, 33 duration
// division cells, the secs*1000 product, 35 bitrate division cells and the output register.
// Synchronous reset clears the valid bits only; there is no kept state.
// A held result freezes the chain only when its last cell holds an item; otherwise
// the chain keeps moving and in_tready stays high.

module musepack_header_properties (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] header_low, [95:64] header_high, [127:96] stream_length
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] header_ok, [10:1] stream_version, [26:11] sample_rate, [28:27] channel_count,
  // [60:29] total_frames, [92:61] sample_frames, [110:93] duration_seconds,
  // [136:111] bitrate_kbps, [143:137] zero
  output logic [143:0] out_tdata
);

  localparam int D1_DW = mphp_pkg::D1_DW;
  localparam int D1_VW = mphp_pkg::D1_VW;
  localparam int D2_DW = mphp_pkg::D2_DW;
  localparam int D2_VW = mphp_pkg::D2_VW;
  localparam int P1_W  = $bits(mphp_pkg::p1_t);
  localparam int P2_W  = $bits(mphp_pkg::p2_t);

  logic           adv;
  logic           out_load;

  logic           dec_v;
  mphp_pkg::dec_t dec;

  logic             d1_v   [0:D1_DW];
  logic [D1_VW-1:0] d1_rem [0:D1_DW];
  logic [D1_DW-1:0] d1_quo [0:D1_DW];
  logic [D1_VW-1:0] d1_dvs [0:D1_DW];
  logic [P1_W-1:0]  d1_pay [0:D1_DW];

  logic             d2_v   [0:D2_DW];
  logic [D2_VW-1:0] d2_rem [0:D2_DW];
  logic [D2_DW-1:0] d2_quo [0:D2_DW];
  logic [D2_VW-1:0] d2_dvs [0:D2_DW];
  logic [P2_W-1:0]  d2_pay [0:D2_DW];

  mphp_pkg::p1_t    p1_end;
  logic [mphp_pkg::SECS_W-1:0] secs_m;
  mphp_pkg::p2_t    m_pay_nxt;

  logic             m_v_r;
  mphp_pkg::p2_t    m_pay_r;
  logic [D2_VW-1:0] m_prod_r;
  logic [D2_DW-1:0] m_dvd_r;

  mphp_pkg::p2_t    p2_end;
  logic [mphp_pkg::BR_W-1:0] bitrate;
  logic             out_valid_r;
  logic [143:0]     out_data_r;
  logic [143:0]     out_data_nxt;

  assign out_load  = !out_valid_r || out_tready;
  assign adv       = out_load || !d2_v[D2_DW];
  assign in_tready = adv;

  mphp_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .in_valid      (in_tvalid),
    .header_low    (in_tdata[63:0]),
    .header_high   (in_tdata[95:64]),
    .stream_length (in_tdata[127:96]),
    .out_valid     (dec_v),
    .out_dec       (dec)
  );

  assign d1_v[0]   = dec_v;
  assign d1_rem[0] = '0;
  assign d1_quo[0] = dec.dividend;
  assign d1_dvs[0] = dec.rate;
  assign d1_pay[0] = dec.pay;

  for (genvar i = 0; i < D1_DW; i++) begin : g_d1
    mphp_div_cell #(.DW(D1_DW), .VW(D1_VW), .PW(P1_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (d1_v[i]),
      .in_rem    (d1_rem[i]),
      .in_quo    (d1_quo[i]),
      .in_dvs    (d1_dvs[i]),
      .in_pay    (d1_pay[i]),
      .out_valid (d1_v[i+1]),
      .out_rem   (d1_rem[i+1]),
      .out_quo   (d1_quo[i+1]),
      .out_dvs   (d1_dvs[i+1]),
      .out_pay   (d1_pay[i+1])
    );
  end

  always_comb begin
    p1_end            = mphp_pkg::p1_t'(d1_pay[D1_DW]);
    secs_m            = p1_end.ok ? d1_quo[D1_DW][mphp_pkg::SECS_W-1:0] : '0;
    m_pay_nxt.ok      = p1_end.ok;
    m_pay_nxt.version = p1_end.version;
    m_pay_nxt.rate    = d1_dvs[D1_DW];
    m_pay_nxt.frames  = p1_end.frames;
    m_pay_nxt.samples = p1_end.samples;
    m_pay_nxt.secs    = secs_m;
    m_pay_nxt.hbr     = p1_end.hbr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= d1_v[D1_DW];
    end
    if (adv) begin
      m_pay_r  <= m_pay_nxt;
      m_prod_r <= D2_VW'({10'd0, secs_m} * D2_VW'(mphp_pkg::KBPS_DIV));
      m_dvd_r  <= {p1_end.len, 3'b000};
    end
  end

  assign d2_v[0]   = m_v_r;
  assign d2_rem[0] = '0;
  assign d2_quo[0] = m_dvd_r;
  assign d2_dvs[0] = m_prod_r;
  assign d2_pay[0] = m_pay_r;

  for (genvar i = 0; i < D2_DW; i++) begin : g_d2
    mphp_div_cell #(.DW(D2_DW), .VW(D2_VW), .PW(P2_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (d2_v[i]),
      .in_rem    (d2_rem[i]),
      .in_quo    (d2_quo[i]),
      .in_dvs    (d2_dvs[i]),
      .in_pay    (d2_pay[i]),
      .out_valid (d2_v[i+1]),
      .out_rem   (d2_rem[i+1]),
      .out_quo   (d2_quo[i+1]),
      .out_dvs   (d2_dvs[i+1]),
      .out_pay   (d2_pay[i+1])
    );
  end

  // remainders and divisors of the final cells are tested but do not change the bitrate result
  always_comb begin
    p2_end = mphp_pkg::p2_t'(d2_pay[D2_DW]);
    if (p2_end.hbr != '0) begin
      bitrate = {17'd0, p2_end.hbr};
    end else if (p2_end.secs == '0 || d2_dvs[D2_DW] == '0 || d2_rem[D2_DW] == '1) begin
      bitrate = (p2_end.secs == '0) ? '0 : d2_quo[D2_DW][mphp_pkg::BR_W-1:0];
    end else begin
      bitrate = d2_quo[D2_DW][mphp_pkg::BR_W-1:0];
    end
    out_data_nxt = {7'd0, bitrate, p2_end.secs, p2_end.samples, p2_end.frames,
                    (p2_end.ok ? mphp_pkg::CH_STEREO : 2'd0), p2_end.rate,
                    p2_end.version, p2_end.ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= d2_v[D2_DW];
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_bad_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[143:1] == '0)
    else $error("rejected header with nonzero fields");

  a_good_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[28:27] == mphp_pkg::CH_STEREO &&
    (out_tdata[26:11] == 16'd44100 || out_tdata[26:11] == 16'd48000 ||
     out_tdata[26:11] == 16'd37800 || out_tdata[26:11] == 16'd32000))
    else $error("accepted header with bad rate or channels");

  a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[110:93] <= 18'd134218)
    else $error("duration out of range");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && d2_v[D2_DW] |=>
      d2_v[D2_DW] && $stable(d2_quo[D2_DW]) && $stable(d2_pay[D2_DW]))
    else $error("last cell moved while result held");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !m_v_r)
    else $error("valid survived reset");
`endif

endmodule
